// File: hw/rtl/vns3d_pkg.sv
`default_nettype none

package vns3d_pkg;

    localparam int GRID_SIZE   = 16;
    localparam int CELL_W      = $clog2(GRID_SIZE);
    localparam int ADDR_W      = 2 * CELL_W;
    localparam int TABLE_DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int NUM_BANKS   = 4;

    localparam int VALUE_W = 16;
    localparam int COORD_W = 16;
    localparam int FRAC_W  = 8;
    localparam int INDEX_W = 8;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    localparam int STEP_W    = 3;
    localparam logic [STEP_W-1:0] LAST_STEP  = 3'd5;
    localparam logic [STEP_W-1:0] PLANE_STEP = 3'd3;

    localparam int ROW_W = VALUE_W + FRAC_W;
    localparam int SMP_W = ROW_W + FRAC_W;
    localparam int SUM_W = SMP_W + 3;
    localparam int LO_W  = 17;
    localparam int HI_W  = SUM_W - LO_W;
    localparam int Q_W   = 48;
    localparam int W_W   = 27;
    localparam int P_W   = 2 * W_W;

    localparam logic [11:0]    AVG_NUM  = 12'd3333;
    localparam logic [Q_W-1:0] HALF_DEN = 48'd655360000;
    localparam int             DEN_SHIFT = 21;
    localparam logic [W_W-1:0] RECIP    = 27'd109951163;
    localparam int             RECIP_SHIFT = 36;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

endpackage

`default_nettype wire

// File: hw/rtl/value_noise_sampler_3d.sv
// Channel | Dir | tdata (low bit up)                                    | tuser
// s_      | in  | table_index[7:0] table_value[23:8] coord_x[39:24]     | func[0]
//         |     | coord_y[55:40] coord_z[71:56]                         |
// m_      | out | noise_value[15:0]                                     | -
//
// A sample item issues one bilinear sample per cycle unless m_ stalls, set by
// the four table banks that deliver the four corners of one sample each cycle.
// A load item is taken when no sample is mid-issue.
// Results pass corner read, blend, sum, scale and output registers in turn.
// Reset (aresetn low, synchronous) clears the sequencer and pipeline valids;
// the table holds no reset value. A stalled m_ side holds the whole pipeline.
`default_nettype none

module value_noise_sampler_3d (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // table_index, table_value, coord_x, coord_y, coord_z
    input  wire logic [vns3d_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // noise_value
    output logic [vns3d_pkg::M_TDATA_W-1:0]      m_tdata
);
    import vns3d_pkg::*;

    logic adv;
    logic s_acc, load_acc, smp_acc;

    logic [INDEX_W-1:0] in_index;
    logic [VALUE_W-1:0] in_value;

    logic                busy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [COORD_W-1:0]  cx_reg, cy_reg, cz_reg;

    logic [COORD_W-1:0]  u_c, v_c;
    logic [1:0]          shift_k;
    logic [COORD_W+1:0]  u_sc, v_sc;
    logic [CELL_W-1:0]   l_cell, t_cell, r_cell, b_cell;
    logic [ADDR_W-1:0]   rd_addr [NUM_BANKS];

    logic [VALUE_W-1:0]  rd_reg [NUM_BANKS];
    logic [FRAC_W-1:0]   ax1_reg, ay1_reg;
    logic                v1_reg, first1_reg, last1_reg;

    logic signed [VALUE_W:0]         d_top, d_bot;
    logic signed [VALUE_W+FRAC_W+1:0] top_full, bot_full;
    logic [ROW_W-1:0]    top_reg, bot_reg;
    logic [FRAC_W-1:0]   ay2_reg;
    logic                v2_reg, first2_reg, last2_reg;

    logic signed [ROW_W:0]           d_col;
    logic signed [ROW_W+FRAC_W+1:0]  smp_full;
    logic [SMP_W-1:0]    smp_reg;
    logic                v3_reg, first3_reg, last3_reg;

    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [SUM_W-1:0]    sum_reg;
    logic                v4_reg;

    logic [HI_W+11:0]    phi_reg;
    logic [LO_W+11:0]    plo_reg;
    logic                v5_reg;

    logic [Q_W-1:0]      q_val;
    logic [W_W-1:0]      w_reg;
    logic                v6_reg;

    logic [P_W-1:0]      prod_reg;
    logic                v7_reg;

    logic [P_W-RECIP_SHIFT-1:0] res_val;
    logic [M_TDATA_W-1:0]       m_tdata_reg;
    logic                       m_tvalid_reg;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv && (!busy_reg || step_reg == LAST_STEP);
    assign s_acc    = s_tvalid && s_tready;
    assign load_acc = s_acc && (func_t'(s_tuser) == FUNC_LOAD);
    assign smp_acc  = s_acc && (func_t'(s_tuser) == FUNC_SAMPLE);

    // sequencer: hold coordinates, advance one octave step per cycle unless m_ stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (adv) begin
            if (busy_reg && step_reg != LAST_STEP) begin
                step_reg <= step_reg + 1'b1;
            end else begin
                busy_reg <= smp_acc;
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (smp_acc) begin
            cx_reg <= s_tdata[INDEX_W+VALUE_W+COORD_W-1:INDEX_W+VALUE_W];
            cy_reg <= s_tdata[INDEX_W+VALUE_W+2*COORD_W-1:INDEX_W+VALUE_W+COORD_W];
            cz_reg <= s_tdata[INDEX_W+VALUE_W+3*COORD_W-1:INDEX_W+VALUE_W+2*COORD_W];
        end
    end

    always_comb begin
        if (step_reg < PLANE_STEP) begin
            u_c     = cx_reg;
            v_c     = cy_reg;
            shift_k = step_reg[1:0];
        end else begin
            u_c     = cy_reg;
            v_c     = cz_reg;
            shift_k = 2'(step_reg - PLANE_STEP);
        end
        u_sc   = {2'b00, u_c} << shift_k;
        v_sc   = {2'b00, v_c} << shift_k;
        l_cell = u_sc[FRAC_W+CELL_W-1:FRAC_W];
        t_cell = v_sc[FRAC_W+CELL_W-1:FRAC_W];
        r_cell = l_cell + 1'b1;
        b_cell = t_cell + 1'b1;
        rd_addr[0] = {l_cell, t_cell};
        rd_addr[1] = {r_cell, t_cell};
        rd_addr[2] = {l_cell, b_cell};
        rd_addr[3] = {r_cell, b_cell};
    end

    // four copies of the table, one corner each
    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        logic [VALUE_W-1:0] mem [TABLE_DEPTH];

        always_ff @(posedge aclk) begin
            if (load_acc && ({1'b0, in_index} < (INDEX_W+1)'(TABLE_DEPTH))) begin
                mem[in_index[ADDR_W-1:0]] <= in_value;
            end
            if (adv) begin
                rd_reg[g] <= mem[rd_addr[g]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax1_reg    <= u_sc[FRAC_W-1:0];
            ay1_reg    <= v_sc[FRAC_W-1:0];
            first1_reg <= (step_reg == '0);
            last1_reg  <= (step_reg == LAST_STEP);
        end
    end

    // row blend: v0*256 + (v1-v0)*a
    always_comb begin
        d_top    = signed'({1'b0, rd_reg[1]}) - signed'({1'b0, rd_reg[0]});
        d_bot    = signed'({1'b0, rd_reg[3]}) - signed'({1'b0, rd_reg[2]});
        top_full = signed'({2'b00, rd_reg[0], {FRAC_W{1'b0}}})
                 + (VALUE_W+FRAC_W+2)'(d_top)
                 * (VALUE_W+FRAC_W+2)'(signed'({1'b0, ax1_reg}));
        bot_full = signed'({2'b00, rd_reg[2], {FRAC_W{1'b0}}})
                 + (VALUE_W+FRAC_W+2)'(d_bot)
                 * (VALUE_W+FRAC_W+2)'(signed'({1'b0, ax1_reg}));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            top_reg    <= top_full[ROW_W-1:0];
            bot_reg    <= bot_full[ROW_W-1:0];
            ay2_reg    <= ay1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
        end
    end

    // column blend: top*256 + (bot-top)*b
    always_comb begin
        d_col    = signed'({1'b0, bot_reg}) - signed'({1'b0, top_reg});
        smp_full = signed'({2'b00, top_reg, {FRAC_W{1'b0}}})
                 + (ROW_W+FRAC_W+2)'(d_col)
                 * (ROW_W+FRAC_W+2)'(signed'({1'b0, ay2_reg}));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            smp_reg    <= smp_full[SMP_W-1:0];
            first3_reg <= first2_reg;
            last3_reg  <= last2_reg;
        end
    end

    assign acc_next = (first3_reg ? '0 : acc_reg) + SUM_W'(smp_reg);

    always_ff @(posedge aclk) begin
        if (adv && v3_reg) begin
            acc_reg <= acc_next;
            if (last3_reg) begin
                sum_reg <= acc_next;
            end
        end
    end

    // scale: (sum*3333 + D/2) / D, D = 2^21 * 625
    always_ff @(posedge aclk) begin
        if (adv) begin
            phi_reg <= (HI_W+12)'(sum_reg[SUM_W-1:LO_W]) * (HI_W+12)'(AVG_NUM);
            plo_reg <= (LO_W+12)'(sum_reg[LO_W-1:0]) * (LO_W+12)'(AVG_NUM);
        end
    end

    assign q_val = Q_W'({phi_reg, {LO_W{1'b0}}}) + Q_W'(plo_reg) + HALF_DEN;

    always_ff @(posedge aclk) begin
        if (adv) begin
            w_reg    <= q_val[DEN_SHIFT+W_W-1:DEN_SHIFT];
            prod_reg <= P_W'(w_reg) * P_W'(RECIP);
        end
    end

    assign res_val = prod_reg[P_W-1:RECIP_SHIFT];

    always_ff @(posedge aclk) begin
        if (adv && v7_reg) begin
            m_tdata_reg <= (res_val > (P_W-RECIP_SHIFT)'({M_TDATA_W{1'b1}}))
                         ? {M_TDATA_W{1'b1}} : res_val[M_TDATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg       <= busy_reg;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg && last3_reg;
            v5_reg       <= v4_reg;
            v6_reg       <= v5_reg;
            v7_reg       <= v6_reg;
            m_tvalid_reg <= v7_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        smp_acc |=> busy_reg && step_reg == '0)
        else $error("sample item did not start issue");

    a_load_between: assert property (@(posedge aclk) disable iff (!aresetn)
        load_acc |-> !busy_reg || step_reg == LAST_STEP)
        else $error("table write during sample issue");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg <= LAST_STEP)
        else $error("step counter out of range");

endmodule

`default_nettype wire
